[hw/rtl/glob_wildcard_matcher_defines.svh]
// assertion macros used by the matcher top level
`ifndef GLOB_WILDCARD_MATCHER_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define GWM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gwm assertion failed");

// next-cycle implication, off while reset is high
`define GWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gwm assertion failed");

`endif

[hw/rtl/gwm_pkg.sv]
package gwm_pkg;

   // default size of the pattern store
   localparam int PATTERN_DEPTH_DEFAULT = 64;
   localparam int CHAR_WIDTH            = 8;

   // operation codes of an input transaction
   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_SUBJECT = 2'd1,
      OP_END     = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   // pattern metacharacters
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_QMARK  = 8'h3f;
   localparam logic [7:0] CH_OPEN   = 8'h5b;
   localparam logic [7:0] CH_CLOSE  = 8'h5d;
   localparam logic [7:0] CH_CARET  = 8'h5e;
   localparam logic [7:0] CH_DASH   = 8'h2d;
   localparam logic [7:0] CH_ESCAPE = 8'h5c;

   typedef struct packed {
      op_type     operation;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

   // result from the walker to the top level
   typedef struct packed {
      logic    strobe;
      rsp_type data;
   } walk_res_type;

   // classification of the pattern byte just read against the subject byte
   typedef struct packed {
      logic same_data;
      logic same_lo;
      logic in_range;
      logic is_star;
      logic is_qmark;
      logic is_open;
      logic is_close;
      logic is_caret;
      logic is_dash;
      logic is_escape;
   } cmp_type;

   // walker states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_ESC,
      ST_STAR,
      ST_WAIT,
      ST_OPEN,
      ST_LO,
      ST_DASH,
      ST_HI,
      ST_VERDICT
   } state_type;

endpackage

[hw/rtl/gwm_ram.sv]
module gwm_ram #(
   parameter int WIDTH = gwm_pkg::CHAR_WIDTH,
   parameter int DEPTH = gwm_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/gwm_cmp.sv]
module gwm_cmp (
   input  logic            fold,
   input  logic [7:0]      subject_char,
   input  logic [7:0]      pattern_char,
   input  logic [7:0]      range_lo,
   output gwm_pkg::cmp_type flags
);

   logic [7:0] up_subject;
   logic [7:0] low_subject;
   logic [7:0] up_pattern;
   logic [7:0] up_lo;
   logic       plain_in;
   logic       up_in;
   logic       low_in;

   // ascii case folding of the operands
   always_comb begin
      up_subject  = subject_char;
      low_subject = subject_char;
      up_pattern  = pattern_char;
      up_lo       = range_lo;
      if (subject_char >= 8'h61 && subject_char <= 8'h7a) begin
         up_subject = subject_char - 8'd32;
      end
      if (subject_char >= 8'h41 && subject_char <= 8'h5a) begin
         low_subject = subject_char + 8'd32;
      end
      if (pattern_char >= 8'h61 && pattern_char <= 8'h7a) begin
         up_pattern = pattern_char - 8'd32;
      end
      if (range_lo >= 8'h61 && range_lo <= 8'h7a) begin
         up_lo = range_lo - 8'd32;
      end
   end

   // range test, pattern byte is the upper bound
   assign plain_in = (subject_char >= range_lo) && (subject_char <= pattern_char);
   assign up_in    = (up_subject >= range_lo) && (up_subject <= pattern_char);
   assign low_in   = (low_subject >= range_lo) && (low_subject <= pattern_char);

   always_comb begin
      flags.same_data = (up_subject == up_pattern);
      flags.same_lo   = (up_subject == up_lo);
      flags.in_range  = plain_in || (fold && up_in) || (fold && low_in);
      flags.is_star   = (pattern_char == gwm_pkg::CH_STAR);
      flags.is_qmark  = (pattern_char == gwm_pkg::CH_QMARK);
      flags.is_open   = (pattern_char == gwm_pkg::CH_OPEN);
      flags.is_close  = (pattern_char == gwm_pkg::CH_CLOSE);
      flags.is_caret  = (pattern_char == gwm_pkg::CH_CARET);
      flags.is_dash   = (pattern_char == gwm_pkg::CH_DASH);
      flags.is_escape = (pattern_char == gwm_pkg::CH_ESCAPE);
   end

endmodule

[hw/rtl/gwm_walk.sv]
module gwm_walk #(
   parameter int PATTERN_DEPTH = gwm_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  gwm_pkg::req_type                 req,
   input  logic [$clog2(PATTERN_DEPTH+1)-1:0] pattern_len,
   input  logic                             overflow,
   input  logic                             fold,
   input  logic [7:0]                       rd_data,
   output logic [$clog2(PATTERN_DEPTH)-1:0] rd_addr,
   output logic                             busy,
   output gwm_pkg::walk_res_type            result
);

   localparam int LW = $clog2(PATTERN_DEPTH + 1);
   localparam int AW = $clog2(PATTERN_DEPTH);

   gwm_pkg::state_type state_ff, state_in;
   logic [LW-1:0]      idx_ff, idx_in;
   logic [LW-1:0]      pos_ff, pos_in;
   logic               waiting_ff, waiting_in;
   logic               to_end_ff, to_end_in;
   logic               failed_ff, failed_in;
   logic [7:0]         char_ff, char_in;
   logic [7:0]         lo_ff, lo_in;
   logic               neg_ff, neg_in;
   logic               hit_ff, hit_in;
   logic               members_ff, members_in;
   logic               done_ff, done_in;
   logic               match_ff, match_in;
   logic               ovf_ff, ovf_in;

   logic               in_len;
   logic [LW-1:0]      idx_next;
   logic               fast_end;
   gwm_pkg::cmp_type   flags;

   // compare the byte read from the store against the subject byte
   gwm_cmp u_cmp (
      .fold         (fold),
      .subject_char (char_ff),
      .pattern_char (rd_data),
      .range_lo     (lo_ff),
      .flags        (flags)
   );

   assign in_len   = (idx_ff < pattern_len);
   assign idx_next = idx_ff + LW'(1);
   assign fast_end = failed_ff || overflow || waiting_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gwm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req.operation)
                  gwm_pkg::OP_SUBJECT: begin
                     if (failed_ff || to_end_ff) begin
                        state_in = gwm_pkg::ST_IDLE;
                     end else if (waiting_ff) begin
                        state_in = gwm_pkg::ST_WAIT;
                     end else begin
                        state_in = gwm_pkg::ST_FIRST;
                     end
                  end
                  gwm_pkg::OP_END: begin
                     state_in = fast_end ? gwm_pkg::ST_IDLE : gwm_pkg::ST_VERDICT;
                  end
                  gwm_pkg::OP_APPEND,
                  gwm_pkg::OP_CLEAR: begin
                     state_in = gwm_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         gwm_pkg::ST_FIRST: begin
            priority if (!in_len) begin
               state_in = gwm_pkg::ST_IDLE;
            end else if (flags.is_open) begin
               state_in = gwm_pkg::ST_OPEN;
            end else if (flags.is_escape) begin
               state_in = gwm_pkg::ST_ESC;
            end else if (flags.is_star) begin
               state_in = gwm_pkg::ST_STAR;
            end else begin
               state_in = gwm_pkg::ST_IDLE;
            end
         end
         gwm_pkg::ST_STAR: begin
            if (!(in_len && flags.is_star)) begin
               state_in = gwm_pkg::ST_IDLE;
            end
         end
         gwm_pkg::ST_OPEN: begin
            state_in = gwm_pkg::ST_LO;
         end
         gwm_pkg::ST_LO: begin
            if (!in_len || flags.is_close) begin
               state_in = gwm_pkg::ST_IDLE;
            end else begin
               state_in = gwm_pkg::ST_DASH;
            end
         end
         gwm_pkg::ST_DASH: begin
            if (in_len && flags.is_dash) begin
               state_in = gwm_pkg::ST_HI;
            end else begin
               state_in = gwm_pkg::ST_LO;
            end
         end
         gwm_pkg::ST_HI: begin
            if (!in_len || flags.is_close) begin
               state_in = gwm_pkg::ST_IDLE;
            end else begin
               state_in = gwm_pkg::ST_LO;
            end
         end
         gwm_pkg::ST_VERDICT: begin
            if (!in_len || !flags.is_star) begin
               state_in = gwm_pkg::ST_IDLE;
            end
         end
         gwm_pkg::ST_ESC,
         gwm_pkg::ST_WAIT: begin
            state_in = gwm_pkg::ST_IDLE;
         end
      endcase
   end

   // match state and walk registers
   always_comb begin
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      waiting_in = waiting_ff;
      to_end_in  = to_end_ff;
      failed_in  = failed_ff;
      char_in    = char_ff;
      lo_in      = lo_ff;
      neg_in     = neg_ff;
      hit_in     = hit_ff;
      members_in = members_ff;
      done_in    = 1'b0;
      match_in   = match_ff;
      ovf_in     = ovf_ff;
      unique case (state_ff)
         gwm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req.operation)
                  gwm_pkg::OP_SUBJECT: begin
                     char_in = req.character;
                     idx_in  = pos_ff;
                  end
                  gwm_pkg::OP_END: begin
                     idx_in = pos_ff;
                     if (fast_end) begin
                        done_in    = 1'b1;
                        match_in   = 1'b0;
                        ovf_in     = overflow;
                        pos_in     = '0;
                        waiting_in = 1'b0;
                        to_end_in  = 1'b0;
                        failed_in  = 1'b0;
                     end
                  end
                  gwm_pkg::OP_CLEAR: begin
                     pos_in     = '0;
                     waiting_in = 1'b0;
                     to_end_in  = 1'b0;
                     failed_in  = 1'b0;
                  end
                  gwm_pkg::OP_APPEND: begin
                     idx_in = pos_ff;
                  end
               endcase
            end
         end
         // first pattern entry at the current position
         gwm_pkg::ST_FIRST: begin
            priority if (!in_len) begin
               failed_in = 1'b1;
            end else if (flags.is_qmark) begin
               pos_in = idx_next;
            end else if (flags.is_open) begin
               idx_in     = idx_next;
               neg_in     = 1'b0;
               hit_in     = 1'b0;
               members_in = 1'b0;
            end else if (flags.is_escape || flags.is_star) begin
               idx_in = idx_next;
            end else if (flags.same_data) begin
               pos_in = idx_next;
            end else begin
               failed_in = 1'b1;
            end
         end
         // escaped literal
         gwm_pkg::ST_ESC: begin
            if (in_len && flags.same_data) begin
               pos_in = idx_next;
            end else begin
               failed_in = 1'b1;
            end
         end
         // skip the star run, then try the first literal after it
         gwm_pkg::ST_STAR: begin
            priority if (in_len && flags.is_star) begin
               idx_in = idx_next;
            end else if (!in_len) begin
               pos_in    = idx_ff;
               to_end_in = 1'b1;
            end else if (flags.same_data) begin
               pos_in = idx_next;
            end else begin
               pos_in     = idx_ff;
               waiting_in = 1'b1;
            end
         end
         // scanning for the literal after a star run
         gwm_pkg::ST_WAIT: begin
            if (in_len && flags.same_data) begin
               pos_in     = idx_next;
               waiting_in = 1'b0;
            end
         end
         // optional negation after the open bracket
         gwm_pkg::ST_OPEN: begin
            if (in_len && flags.is_caret) begin
               neg_in = 1'b1;
               idx_in = idx_next;
            end
         end
         // set member or closing bracket
         gwm_pkg::ST_LO: begin
            priority if (!in_len) begin
               failed_in = 1'b1;
            end else if (flags.is_close) begin
               if (!members_ff || !(hit_ff ^ neg_ff)) begin
                  failed_in = 1'b1;
               end else begin
                  pos_in = idx_next;
               end
            end else begin
               members_in = 1'b1;
               lo_in      = rd_data;
               idx_in     = idx_next;
            end
         end
         // range dash or single member
         gwm_pkg::ST_DASH: begin
            if (in_len && flags.is_dash) begin
               idx_in = idx_next;
            end else if (flags.same_lo) begin
               hit_in = 1'b1;
            end
         end
         // range upper bound
         gwm_pkg::ST_HI: begin
            if (!in_len || flags.is_close) begin
               failed_in = 1'b1;
            end else begin
               if (flags.in_range) begin
                  hit_in = 1'b1;
               end
               idx_in = idx_next;
            end
         end
         // remaining pattern must be all stars
         gwm_pkg::ST_VERDICT: begin
            if (!in_len || !flags.is_star) begin
               done_in    = 1'b1;
               match_in   = !in_len;
               ovf_in     = overflow;
               pos_in     = '0;
               waiting_in = 1'b0;
               to_end_in  = 1'b0;
               failed_in  = 1'b0;
            end else begin
               idx_in = idx_next;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gwm_pkg::ST_IDLE;
         pos_ff     <= '0;
         waiting_ff <= 1'b0;
         to_end_ff  <= 1'b0;
         failed_ff  <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         waiting_ff <= waiting_in;
         to_end_ff  <= to_end_in;
         failed_ff  <= failed_in;
         done_ff    <= done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      char_ff    <= char_in;
      lo_ff      <= lo_in;
      neg_ff     <= neg_in;
      hit_ff     <= hit_in;
      members_ff <= members_in;
      match_ff   <= match_in;
      ovf_ff     <= ovf_in;
   end

   // outputs
   always_comb begin
      busy                         = (state_ff != gwm_pkg::ST_IDLE);
      rd_addr                      = idx_in[AW-1:0];
      result.strobe                = done_ff;
      result.data.matched          = match_ff;
      result.data.pattern_overflow = ovf_ff;
   end

endmodule

[hw/rtl/glob_wildcard_matcher.sv]
// glob wildcard matcher
// transactions enter on start/req_data and are taken when start is high and
// busy is low. req_data.operation appends a pattern byte, feeds a subject
// byte, ends the subject or clears the pattern.
// append and clear never raise busy.
// a subject byte holds busy while the walker reads the pattern entries it
// examines: a plain literal or '?', each star of a run or an escape and its
// literal, and the members and ranges of a bracket set; a byte after a
// failure or after a trailing star run does not raise busy.
// end of subject strobes rsp_strobe with rsp_data in the cycle after it is
// taken when the match already failed, a star run still waits for its
// literal or the pattern overflowed; otherwise the walker first reads the
// remaining pattern entries to check that they are all stars.
// the store has a single registered read port that yields one entry per cycle.
// the result is shown for one cycle only; the receiver cannot stall it.
// reset empties the pattern, clears the match state and sets case_fold;
// the store contents need no clearing. csr_write loads case_fold at once.
module glob_wildcard_matcher #(
   parameter int PATTERN_DEPTH = gwm_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gwm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output gwm_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_wdata
);

`include "glob_wildcard_matcher_defines.svh"

   localparam int LW = $clog2(PATTERN_DEPTH + 1);
   localparam int AW = $clog2(PATTERN_DEPTH);

   logic                  fold_ff, fold_in;
   logic [LW-1:0]         len_ff, len_in;
   logic                  overflow_ff, overflow_in;
   logic                  accept;
   logic                  end_taken;
   logic                  store_full;
   logic                  wr_en;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            rd_data;
   gwm_pkg::walk_res_type result;

   assign accept     = start && !busy;
   assign end_taken  = accept && (req_data.operation == gwm_pkg::OP_END);
   assign store_full = (len_ff == LW'(PATTERN_DEPTH));
   assign wr_en      = accept && (req_data.operation == gwm_pkg::OP_APPEND) && !store_full;

   // pattern length, overflow and case fold register
   always_comb begin
      len_in      = len_ff;
      overflow_in = overflow_ff;
      fold_in     = fold_ff;
      if (csr_write) begin
         fold_in = csr_wdata;
      end
      if (accept && req_data.operation == gwm_pkg::OP_APPEND) begin
         if (store_full) begin
            overflow_in = 1'b1;
         end else begin
            len_in = len_ff + LW'(1);
         end
      end else if (accept && req_data.operation == gwm_pkg::OP_CLEAR) begin
         len_in      = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff     <= 1'b1;
         len_ff      <= '0;
         overflow_ff <= 1'b0;
      end else begin
         fold_ff     <= fold_in;
         len_ff      <= len_in;
         overflow_ff <= overflow_in;
      end
   end

   // pattern store
   gwm_ram #(
      .WIDTH (gwm_pkg::CHAR_WIDTH),
      .DEPTH (PATTERN_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[AW-1:0]),
      .wr_data (req_data.character),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // match sequencer
   gwm_walk #(
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .pattern_len (len_ff),
      .overflow    (overflow_ff),
      .fold        (fold_ff),
      .rd_data     (rd_data),
      .rd_addr     (rd_addr),
      .busy        (busy),
      .result      (result)
   );

   assign rsp_strobe = result.strobe;
   assign rsp_data   = result.data;

   // a result follows a taken end transaction or a busy walk
   `GWM_ASSERT_IMPLY(a_rsp_cause, clock, reset, rsp_strobe, $past(end_taken) || $past(busy))
   // the walker is idle whenever it shows a result
   `GWM_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_strobe, !busy)
   // overflow is only flagged once the store is full
   `GWM_ASSERT_IMPLY(a_ovf_full, clock, reset, overflow_ff, len_ff == LW'(PATTERN_DEPTH))
   // a taken append grows the length unless the store was full
   `GWM_ASSERT_NEXT(a_len_grow, clock, reset, wr_en, len_ff == $past(len_ff) + LW'(1))

endmodule

[tb/sv/glob_wildcard_matcher_test.sv]
module glob_wildcard_matcher_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gwm_pkg::*;

   localparam int DEPTH         = PATTERN_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int SETTLE_CYCLES = 400;
   localparam int PHASE_ITEMS   = 283;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic    csr_wdata = 1'b0;

   glob_wildcard_matcher #(
      .PATTERN_DEPTH(DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   // stimulus and scoreboard storage
   req_type pending_items[$];
   rsp_type verdict_queue[$];
   logic    taken = 1'b0;
   int      gap_pct = 0;
   int      item_count = 0;
   int      error_count = 0;
   int      cycle_count = 0;

   // shadow copy of the matcher state
   logic [7:0] pat_mem [DEPTH];
   int         pat_len;
   int         pat_pos;
   bit         star_wait;
   bit         star_end;
   bit         fail_flag;
   bit         ovf_flag;
   bit         fold_on;

   string      letter_pool = "abcxyzABCXYZ019";
   logic [7:0] meta_chars [7] = '{CH_STAR, CH_QMARK, CH_OPEN, CH_CLOSE,
                                  CH_CARET, CH_DASH, CH_ESCAPE};

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] to_upper(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic bit same_letter(logic [7:0] a, logic [7:0] b);
      return to_upper(a) == to_upper(b);
   endfunction

   function automatic void clear_match_state();
      pat_pos   = 0;
      star_wait = 1'b0;
      star_end  = 1'b0;
      fail_flag = 1'b0;
   endfunction

   // bracket set starting at index at; next_at points past the closing bracket
   function automatic bit bracket_hit(int at, logic [7:0] c, output int next_at);
      int         i;
      bit         negate;
      bit         hit;
      bit         members;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] up;
      logic [7:0] dn;
      i       = at + 1;
      negate  = 1'b0;
      hit     = 1'b0;
      members = 1'b0;
      next_at = 0;
      up      = to_upper(c);
      dn      = to_lower(c);
      if (i < pat_len && pat_mem[i] == CH_CARET) begin
         negate = 1'b1;
         i++;
      end
      forever begin
         if (i >= pat_len)
            return 1'b0;
         lo = pat_mem[i];
         if (lo == CH_CLOSE) begin
            if (!members)
               return 1'b0;
            break;
         end
         members = 1'b1;
         if (i + 1 < pat_len && pat_mem[i + 1] == CH_DASH) begin
            if (i + 2 >= pat_len)
               return 1'b0;
            hi = pat_mem[i + 2];
            if (hi == CH_CLOSE)
               return 1'b0;
            if ((c >= lo && c <= hi) ||
                (fold_on && up >= lo && up <= hi) ||
                (fold_on && dn >= lo && dn <= hi))
               hit = 1'b1;
            i += 3;
         end else begin
            if (same_letter(c, lo))
               hit = 1'b1;
            i += 1;
         end
      end
      next_at = i + 1;
      return hit ^ negate;
   endfunction

   // advance the match by one subject byte
   function automatic void feed_subject_char(logic [7:0] c);
      int         pp;
      int         nx;
      logic [7:0] ch;
      pp = pat_pos;
      if (fail_flag || star_end)
         return;
      if (!star_wait) begin
         if (pp >= pat_len) begin
            fail_flag = 1'b1;
            return;
         end
         ch = pat_mem[pp];
         if (ch == CH_QMARK) begin
            pat_pos = pp + 1;
            return;
         end
         if (ch == CH_OPEN) begin
            if (bracket_hit(pp, c, nx))
               pat_pos = nx;
            else
               fail_flag = 1'b1;
            return;
         end
         if (ch == CH_ESCAPE) begin
            if (pp + 1 < pat_len && same_letter(c, pat_mem[pp + 1]))
               pat_pos = pp + 2;
            else
               fail_flag = 1'b1;
            return;
         end
         if (ch != CH_STAR) begin
            if (same_letter(c, ch))
               pat_pos = pp + 1;
            else
               fail_flag = 1'b1;
            return;
         end
         // skip the star run, then scan for the byte after it
         while (pp < pat_len && pat_mem[pp] == CH_STAR)
            pp++;
         pat_pos = pp;
         if (pp >= pat_len) begin
            star_end = 1'b1;
            return;
         end
         star_wait = 1'b1;
      end
      if (pp < pat_len && same_letter(c, pat_mem[pp])) begin
         pat_pos   = pp + 1;
         star_wait = 1'b0;
      end
   endfunction

   function automatic bit match_verdict();
      if (fail_flag || ovf_flag || star_wait)
         return 1'b0;
      for (int i = pat_pos; i < pat_len; i++)
         if (pat_mem[i] != CH_STAR)
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic void apply_transaction(req_type t);
      rsp_type r;
      case (t.operation)
         OP_APPEND: begin
            if (pat_len < DEPTH) begin
               pat_mem[pat_len] = t.character;
               pat_len++;
            end else begin
               ovf_flag = 1'b1;
            end
         end
         OP_SUBJECT: begin
            feed_subject_char(t.character);
         end
         OP_END: begin
            r.matched          = match_verdict();
            r.pattern_overflow = ovf_flag;
            verdict_queue.push_back(r);
            clear_match_state();
         end
         default: begin
            pat_len  = 0;
            ovf_flag = 1'b0;
            clear_match_state();
         end
      endcase
   endfunction

   task automatic report(string what, logic got, logic want);
      $display("mismatch at cycle %0d: %s got %b expected %b", cycle_count, what, got, want);
      error_count++;
   endtask

   // driver: present the next transaction once the previous one is taken
   always @(negedge clock) begin
      if (!start || taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
            start    <= 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: track accepted transactions, check results
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("glob_wildcard_matcher test failed");
         $finish;
      end else if (reset) begin
         pat_len  = 0;
         ovf_flag = 1'b0;
         fold_on  = 1'b1;
         clear_match_state();
         taken <= 1'b0;
      end else begin
         if (csr_write)
            fold_on = csr_wdata;
         if (rsp_strobe) begin
            if (verdict_queue.size() == 0) begin
               report("unexpected result, matched", rsp_data.matched, 1'bx);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_data.matched !== want.matched)
                  report("matched", rsp_data.matched, want.matched);
               if (rsp_data.pattern_overflow !== want.pattern_overflow)
                  report("pattern_overflow", rsp_data.pattern_overflow,
                         want.pattern_overflow);
            end
         end
         if (start && !busy)
            apply_transaction(req_data);
         taken <= start && !busy;
      end
   end

   // stimulus helpers
   task automatic push_op(op_type op, logic [7:0] c);
      req_type t;
      t.operation = op;
      t.character = c;
      pending_items.push_back(t);
      item_count++;
   endtask

   task automatic add_pattern(string s);
      for (int i = 0; i < s.len(); i++)
         push_op(OP_APPEND, s[i]);
   endtask

   task automatic add_subject(string s);
      for (int i = 0; i < s.len(); i++)
         push_op(OP_SUBJECT, s[i]);
      push_op(OP_END, 8'($urandom_range(255)));
   endtask

   function automatic logic [7:0] pick_letter();
      return letter_pool[$urandom_range(letter_pool.len() - 1)];
   endfunction

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return pick_letter();
      if (r < 75)
         return meta_chars[$urandom_range(6)];
      return 8'($urandom_range(255));
   endfunction

   function automatic bit is_meta(logic [7:0] c);
      foreach (meta_chars[i])
         if (c == meta_chars[i])
            return 1'b1;
      return 1'b0;
   endfunction

   task automatic push_noise();
      push_op(op_type'($urandom_range(3)), 8'($urandom_range(255)));
   endtask

   // one pattern, then a few subjects against it
   task automatic build_sequence();
      logic [7:0] pat[$];
      logic [7:0] hint[$];
      logic [7:0] subj[$];
      logic [7:0] c;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] first;
      int         target;
      int         n;
      int         nsub;
      bit         negate;
      target = ($urandom_range(99) < 4) ? $urandom_range(60, 72) : $urandom_range(1, 14);
      while (pat.size() < target) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               c = pick_char();
               if (is_meta(c))
                  pat.push_back(CH_ESCAPE);
               pat.push_back(c);
               hint.push_back($urandom_range(1) ? to_upper(c) : to_lower(c));
            end
            4: begin
               pat.push_back(CH_QMARK);
               hint.push_back(8'($urandom_range(255)));
            end
            5: begin
               n = $urandom_range(1, 3);
               repeat (n) pat.push_back(CH_STAR);
               n = $urandom_range(0, 3);
               repeat (n) hint.push_back(pick_letter());
            end
            6: begin
               c = 8'($urandom_range(255));
               pat.push_back(CH_ESCAPE);
               pat.push_back(c);
               hint.push_back(c);
            end
            default: begin
               // bracket set, now and then empty or unterminated
               negate = $urandom_range(99) < 30;
               first  = pick_letter();
               pat.push_back(CH_OPEN);
               if (negate)
                  pat.push_back(CH_CARET);
               n = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 3);
               for (int k = 0; k < n; k++) begin
                  lo = pick_char();
                  if (lo == CH_CLOSE)
                     lo = "m";
                  if ($urandom_range(1)) begin
                     hi = pick_char();
                     if (hi == CH_CLOSE && $urandom_range(99) < 80)
                        hi = lo;
                     pat.push_back(lo);
                     pat.push_back(CH_DASH);
                     pat.push_back(hi);
                     if (k == 0)
                        first = (hi >= lo) ? 8'(lo + $urandom_range(hi - lo)) : lo;
                  end else begin
                     pat.push_back(lo);
                     if (k == 0)
                        first = lo;
                  end
               end
               if ($urandom_range(99) >= 5)
                  pat.push_back(CH_CLOSE);
               hint.push_back((negate || n == 0) ? pick_letter() : first);
            end
         endcase
      end
      if ($urandom_range(99) < 3)
         pat.push_back(CH_ESCAPE);
      push_op(OP_CLEAR, 8'($urandom_range(255)));
      foreach (pat[i])
         push_op(OP_APPEND, pat[i]);
      nsub = $urandom_range(1, 4);
      repeat (nsub) begin
         subj.delete();
         if ($urandom_range(99) < 65) begin
            subj = hint;
            if (subj.size() != 0 && $urandom_range(99) < 25)
               subj[$urandom_range(subj.size() - 1)] = pick_char();
            if ($urandom_range(99) < 10)
               subj.push_back(pick_char());
         end else begin
            n = $urandom_range(0, 6);
            repeat (n) subj.push_back(pick_char());
         end
         foreach (subj[i]) begin
            if ($urandom_range(99) < 3)
               push_noise();
            push_op(OP_SUBJECT, subj[i]);
         end
         push_op(OP_END, 8'($urandom_range(255)));
      end
   endtask

   // hold the sender until every expected result is back
   task automatic drain();
      while (pending_items.size() != 0 || start || verdict_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fold(logic value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(int items, int gap);
      int phase_end;
      int batch_end;
      gap_pct   = gap;
      phase_end = item_count + items;
      while (item_count < phase_end) begin
         batch_end = item_count + $urandom_range(50, 120);
         while (item_count < batch_end && item_count < phase_end)
            build_sequence();
         drain();
      end
   endtask

   // sequencer
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed cases with the reset folding setting
      gap_pct = 9;
      push_op(OP_END, 8'hff);
      push_op(OP_SUBJECT, 8'h00);
      push_op(OP_END, 8'h00);
      push_op(OP_CLEAR, 8'hff);
      push_op(OP_APPEND, 8'hff);
      push_op(OP_APPEND, CH_QMARK);
      push_op(OP_SUBJECT, 8'hff);
      push_op(OP_SUBJECT, 8'h00);
      push_op(OP_END, 8'h5a);
      push_op(OP_CLEAR, 8'h00);
      add_pattern("[^]");
      add_subject("x");
      push_op(OP_CLEAR, 8'ha5);
      add_pattern("a\\");
      add_subject("ab");
      settle();

      // random phases across both folding settings and idle rates
      write_fold(1'b0);
      run_phase(PHASE_ITEMS, 9);
      settle();
      write_fold(1'b1);
      run_phase(PHASE_ITEMS, 84);
      settle();
      write_fold(1'b0);
      run_phase(PHASE_ITEMS, 0);
      settle();
      write_fold(1'b1);
      run_phase(PHASE_ITEMS, 0);
      settle();

      if (error_count == 0)
         $display("glob_wildcard_matcher test passed");
      else
         $display("glob_wildcard_matcher test failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_ram.sv
hw/rtl/gwm_cmp.sv
hw/rtl/gwm_walk.sv
hw/rtl/glob_wildcard_matcher.sv
tb/sv/glob_wildcard_matcher_test.sv
